FILE: sv/psp_pkg.sv
// psp_pkg: shared types, constants and digit helpers for the phantom rtc serial port
// used by the codec and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

  localparam logic [63:0] UNLOCK_PATTERN = 64'h5CA3_3AC5_5CA3_3AC5;
  localparam logic [7:0]  FRAME_LAST_BIT = 8'd63;
  localparam logic [6:0]  YEAR_WRAP      = 7'd100;
  localparam logic [4:0]  HALF_DAY       = 5'd12;
  localparam logic [3:0]  YEAR_BIAS      = 4'd10;

  typedef enum logic [1:0] {
    CMD_BIT0     = 2'd0,
    CMD_BIT1     = 2'd1,
    CMD_TALKBACK = 2'd2,
    CMD_OTHER    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] hundredths;
  } cur_time_t;

  typedef struct packed {
    logic       twelve_hour;
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [3:0] weekday;
    logic [5:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic [7:0] hundredths;
  } set_time_t;

  // quotient by ten through a reciprocal, exact for values below 160
  function automatic logic [3:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [7:0] q10;
    q10 = {4'd0, div10(v)} * 8'd10;
    return 4'(v - q10);
  endfunction

  function automatic logic [7:0] bcd_join(input logic [3:0] tens, input logic [3:0] ones);
    return {4'd0, ones} + {4'd0, tens} * 8'd10;
  endfunction

endpackage

`default_nettype wire

FILE: sv/psp_if.sv
// psp_in_if / psp_out_if: valid-ready channels for access words and result words
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface psp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [6:0] cur_year;
  logic [3:0] cur_month;
  logic [4:0] cur_day;
  logic [2:0] cur_weekday;
  logic [4:0] cur_hour;
  logic [5:0] cur_minute;
  logic [5:0] cur_second;
  logic [6:0] cur_hundredths;

  modport source (output valid, cmd, cur_year, cur_month, cur_day, cur_weekday,
                  cur_hour, cur_minute, cur_second, cur_hundredths, input ready);
  modport sink   (input valid, cmd, cur_year, cur_month, cur_day, cur_weekday,
                  cur_hour, cur_minute, cur_second, cur_hundredths, output ready);
endinterface

interface psp_out_if;
  logic       valid;
  logic       ready;
  logic       read_bit;
  logic       time_set_valid;
  logic [7:0] set_year;
  logic [7:0] set_month;
  logic [7:0] set_day;
  logic [3:0] set_weekday;
  logic [5:0] set_hour;
  logic [7:0] set_minute;
  logic [7:0] set_second;
  logic [7:0] set_hundredths;

  modport source (output valid, read_bit, time_set_valid, set_year, set_month, set_day,
                  set_weekday, set_hour, set_minute, set_second, set_hundredths,
                  input ready);
  modport sink   (input valid, read_bit, time_set_valid, set_year, set_month, set_day,
                  set_weekday, set_hour, set_minute, set_second, set_hundredths,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/phantom_rtc_serial_port.sv
// phantom_rtc_serial_port: serial rtc port with unlock pattern, talkback and frame decode
// depends on psp_pkg, psp_if and psp_frame_codec
//
//   channel   direction  kind          content
//   req_i     in         valid/ready   one bus access word: cmd plus current time
//   rsp_o     out        valid/ready   one result word per access word
//   cfg_*     in         write strobe  write_enable register
//
// the shift, the pattern compare and the bcd pack or decode are combinational and
// all sit between the state registers and the result register
// a new word is taken every cycle while the result register is empty or drained
// rsp_o stalling holds the result register and pauses req_i until it drains
// asynchronous active-low reset clears all control state and the result valid, not the result payload
`timescale 1ns / 1ps
`default_nettype none

module phantom_rtc_serial_port (
  input  logic   clk_i,
  input  logic   rst_ni,
  psp_in_if.sink    req_i,
  psp_out_if.source rsp_o,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i
);
  import psp_pkg::*;

  logic [63:0] shift_in_q, shift_in_d;
  logic [63:0] shift_out_q, shift_out_d;
  logic [7:0]  bit_count_q, bit_count_d;
  logic        unlocked_q, unlocked_d;
  logic        twelve_hour_q, twelve_hour_d;
  logic        write_enable_q;

  logic        rsp_valid_q, rsp_valid_d;
  logic        read_bit_q, read_bit_d;
  logic        set_flag_q, set_flag_d;
  set_time_t   set_q, set_d;

  logic        accept;
  logic [63:0] shift_new;
  logic        decode;
  cur_time_t   cur;
  logic [63:0] packed_frame;
  set_time_t   dec;
  cmd_e        cmd;

  // result register empties or drains this cycle: room for the next word
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd         = cmd_e'(req_i.cmd);

  assign cur = '{year: req_i.cur_year, month: req_i.cur_month, day: req_i.cur_day,
                 weekday: req_i.cur_weekday, hour: req_i.cur_hour,
                 minute: req_i.cur_minute, second: req_i.cur_second,
                 hundredths: req_i.cur_hundredths};

  // bit stream enters at the top, lsb first
  assign shift_new = {req_i.cmd[0], shift_in_q[63:1]};
  assign decode    = unlocked_q && (bit_count_q == 8'd0);

  // the unlock compare is gated off on a decode, so a decode access never unlocks
  // and the pack may use the stored hour mode; a decode leaves a nibble in shift_in
  psp_frame_codec u_codec (
    .cur_i         (cur),
    .twelve_hour_i (twelve_hour_q),
    .frame_i       (shift_new),
    .frame_o       (packed_frame),
    .set_o         (dec)
  );

  always_comb begin
    shift_in_d    = shift_in_q;
    shift_out_d   = shift_out_q;
    bit_count_d   = bit_count_q;
    unlocked_d    = unlocked_q;
    twelve_hour_d = twelve_hour_q;
    rsp_valid_d   = rsp_valid_q && !rsp_o.ready;
    read_bit_d    = read_bit_q;
    set_flag_d    = set_flag_q;
    set_d         = set_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
      read_bit_d  = 1'b0;
      set_flag_d  = 1'b0;
      set_d       = '0;
      unique case (cmd)
        CMD_BIT0, CMD_BIT1: begin
          shift_in_d = shift_new;
          if (unlocked_q) begin
            if (decode) begin
              // frame complete: report the written time, keep the top nibble
              twelve_hour_d = dec.twelve_hour;
              set_flag_d    = write_enable_q;
              set_d         = dec;
              shift_in_d    = {60'd0, shift_new[63:60]};
              unlocked_d    = 1'b0;
            end
            bit_count_d = bit_count_q - 8'd1;
          end
          if (!decode && shift_new == UNLOCK_PATTERN) begin
            shift_out_d = packed_frame;
            shift_in_d  = '0;
            bit_count_d = FRAME_LAST_BIT;
            unlocked_d  = 1'b1;
          end
        end
        CMD_TALKBACK: begin
          read_bit_d = shift_out_q[0];
          if (bit_count_q != 8'd0) begin
            shift_out_d = {1'b0, shift_out_q[63:1]};
            bit_count_d = bit_count_q - 8'd1;
          end else begin
            unlocked_d = 1'b0;
          end
        end
        CMD_OTHER: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_in_q     <= '0;
      shift_out_q    <= '0;
      bit_count_q    <= '0;
      unlocked_q     <= 1'b0;
      twelve_hour_q  <= 1'b0;
      write_enable_q <= 1'b0;
      rsp_valid_q    <= 1'b0;
    end else begin
      shift_in_q    <= shift_in_d;
      shift_out_q   <= shift_out_d;
      bit_count_q   <= bit_count_d;
      unlocked_q    <= unlocked_d;
      twelve_hour_q <= twelve_hour_d;
      rsp_valid_q   <= rsp_valid_d;
      if (cfg_we_i) begin
        write_enable_q <= cfg_wdata_i;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    read_bit_q <= read_bit_d;
    set_flag_q <= set_flag_d;
    set_q      <= set_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.read_bit       = read_bit_q;
  assign rsp_o.time_set_valid = set_flag_q;
  assign rsp_o.set_year       = set_q.year;
  assign rsp_o.set_month      = set_q.month;
  assign rsp_o.set_day        = set_q.day;
  assign rsp_o.set_weekday    = set_q.weekday;
  assign rsp_o.set_hour       = set_q.hour;
  assign rsp_o.set_minute     = set_q.minute;
  assign rsp_o.set_second     = set_q.second;
  assign rsp_o.set_hundredths = set_q.hundredths;

endmodule

`default_nettype wire

FILE: sv/psp_frame_codec.sv
// psp_frame_codec: packs the current time into a bcd frame and decodes a written frame
// depends on psp_pkg
`timescale 1ns / 1ps
`default_nettype none

module psp_frame_codec (
  input  psp_pkg::cur_time_t cur_i,
  input  logic               twelve_hour_i,
  input  logic [63:0]        frame_i,
  output logic [63:0]        frame_o,
  output psp_pkg::set_time_t set_o
);
  import psp_pkg::*;

  logic [6:0] year_m;
  logic [4:0] hour_p;
  logic       pm;
  logic [3:0] hour_tens;
  logic [3:0] nib [16];
  logic [3:0] ctl;
  logic [5:0] hour_d;

  // pack
  always_comb begin
    year_m = (cur_i.year >= YEAR_WRAP) ? cur_i.year - YEAR_WRAP : cur_i.year;
    hour_p = cur_i.hour;
    pm     = 1'b0;
    if (twelve_hour_i && cur_i.hour > HALF_DAY) begin
      hour_p = cur_i.hour - HALF_DAY;
      pm     = 1'b1;
    end
    hour_tens = div10({3'd0, hour_p});
    frame_o = {div10({1'b0, year_m}) + YEAR_BIAS, mod10({1'b0, year_m}),
               div10({4'd0, cur_i.month}), mod10({4'd0, cur_i.month}),
               div10({3'd0, cur_i.day}), mod10({3'd0, cur_i.day}),
               4'd0, {1'b0, cur_i.weekday},
               {2'b00, hour_tens[1] | pm, hour_tens[0]}, mod10({3'd0, hour_p}),
               div10({2'd0, cur_i.minute}), mod10({2'd0, cur_i.minute}),
               div10({2'd0, cur_i.second}), mod10({2'd0, cur_i.second}),
               div10({1'b0, cur_i.hundredths}), mod10({1'b0, cur_i.hundredths})};
  end

  // decode
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      nib[k] = frame_i[4*k +: 4];
    end
    ctl = nib[7];
    if (ctl[3]) begin
      hour_d = {2'd0, nib[6]} + (ctl[0] ? 6'd10 : 6'd0) + (ctl[1] ? 6'd12 : 6'd0);
    end else begin
      hour_d = {2'd0, nib[6]} + {4'd0, ctl[1:0]} * 6'd10;
    end
    set_o.twelve_hour = ctl[3];
    set_o.year        = bcd_join(nib[15], nib[14]);
    set_o.month       = bcd_join(nib[13], nib[12]);
    set_o.day         = bcd_join(nib[11], nib[10]);
    set_o.weekday     = nib[8];
    set_o.hour        = hour_d;
    set_o.minute      = bcd_join(nib[5], nib[4]);
    set_o.second      = bcd_join(nib[3], nib[2]);
    set_o.hundredths  = bcd_join(nib[1], nib[0]);
  end

endmodule

`default_nettype wire

FILE: sv/psp_checker.sv
// psp_checker: port-level checks of the phantom rtc serial port, bound to the top level
// depends on phantom_rtc_serial_port and psp_if
`timescale 1ns / 1ps
`default_nettype none

module psp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       read_bit_i,
  input logic       time_set_valid_i,
  input logic [5:0] set_hour_i
);

  // every accepted word shows a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted word gave no result");

  // a drained result with no new word leaves nothing behind
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_ready_i && !(req_valid_i && req_ready_i) |=> !rsp_valid_i)
    else $error("result repeated");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(read_bit_i)
      && $stable(time_set_valid_i) && $stable(set_hour_i))
    else $error("stalled result changed");

  // a decode access is a bit access, so it never carries talkback data, and its hour is at most 45
  a_decode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && time_set_valid_i |-> !read_bit_i && set_hour_i <= 6'd45)
    else $error("decode result inconsistent");

endmodule

bind phantom_rtc_serial_port psp_checker u_psp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .read_bit_i       (rsp_o.read_bit),
  .time_set_valid_i (rsp_o.time_set_valid),
  .set_hour_i       (rsp_o.set_hour)
);

`default_nettype wire
